FILE: hw/rtl/cour_pkg.sv
// Shared constants, result codes and the arctangent table of the circle union ratio block.
package cour_pkg;

    // Partial overlap lengths are brought down to this many bits.
    localparam int PART_BITS = 15;
    // Containment radii are brought down to this many bits.
    localparam int CONT_BITS = 31;
    localparam int SQRT_STEPS = 32;
    localparam int CORDIC_STEPS = 30;
    // CORDIC x and y, signed.
    localparam int XY_W = 40;
    // Angle accumulator, signed Q30 radians.
    localparam int ANG_W = 34;

    localparam logic [31:0] PI_Q30 = 32'd3373259426;
    localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;

    localparam logic [1:0] KIND_APART = 2'd0;
    localparam logic [1:0] KIND_PARTIAL = 2'd1;
    localparam logic [1:0] KIND_CONTAINED = 2'd2;

    typedef struct packed {
        logic [XY_W-1:0]  x;
        logic [XY_W-1:0]  y;
        logic [ANG_W-1:0] z;
    } xyz_t;

    // atan(2^-idx) in Q30 radians, truncated.
    function automatic logic [29:0] atan_q30(input int idx);
        logic [29:0] val;
        case (idx)
            0:       val = 30'h3243F6A8;
            1:       val = 30'h1DAC6705;
            2:       val = 30'h0FADBAFC;
            3:       val = 30'h07F56EA6;
            4:       val = 30'h03FEAB76;
            5:       val = 30'h01FFD55B;
            6:       val = 30'h00FFFAAA;
            7:       val = 30'h007FFF55;
            8:       val = 30'h003FFFEA;
            9:       val = 30'h001FFFFD;
            10:      val = 30'h000FFFFF;
            11:      val = 30'h0007FFFF;
            12:      val = 30'h0003FFFF;
            13:      val = 30'h0001FFFF;
            14:      val = 30'h0000FFFF;
            15:      val = 30'h00007FFF;
            16:      val = 30'h00003FFF;
            17:      val = 30'h00001FFF;
            18:      val = 30'h00000FFF;
            19:      val = 30'h000007FF;
            20:      val = 30'h000003FF;
            21:      val = 30'h000001FF;
            22:      val = 30'h000000FF;
            23:      val = 30'h0000007F;
            24:      val = 30'h0000003F;
            25:      val = 30'h0000001F;
            26:      val = 30'h0000000F;
            27:      val = 30'h00000008;
            28:      val = 30'h00000004;
            29:      val = 30'h00000002;
            default: val = 30'h00000000;
        endcase
        return val;
    endfunction

endpackage

FILE: hw/rtl/cour_query_if.sv
// Query channel: two radii and the centre distance with a valid/ready handshake.
interface cour_query_if #(
    parameter int LENGTH_BITS = 16
);
    logic                   valid;
    logic                   ready;
    logic [LENGTH_BITS-1:0] radius_a;
    logic [LENGTH_BITS-1:0] radius_b;
    logic [LENGTH_BITS-1:0] centre_gap;

    modport source (output valid, output radius_a, output radius_b, output centre_gap,
                    input ready);
    modport sink (input valid, input radius_a, input radius_b, input centre_gap,
                  output ready);
endinterface

FILE: hw/rtl/cour_result_if.sv
// Result channel: union ratio and overlap kind with a valid/ready handshake.
interface cour_result_if #(
    parameter int RATIO_BITS = 17
);
    logic                  valid;
    logic                  ready;
    logic [RATIO_BITS-1:0] union_ratio;
    logic [1:0]            overlap_kind;

    modport source (output valid, output union_ratio, output overlap_kind, input ready);
    modport sink (input valid, input union_ratio, input overlap_kind, output ready);
endinterface

FILE: hw/rtl/circle_overlap_union_ratio.sv
// Circle union ratio: fully pipelined union-area over summed-area computation.
//
// Takes one query per clock while query.ready is high and returns one result per query,
// in order. The pipeline holds five input and squaring stages, 32 square-root stages
// (one result bit each), a pre-rotation stage and 30 CORDIC stages that run both chord
// angles side by side, five stages of clamping, area products, lens subtraction,
// numerator selection and saturation flagging, one restoring-division stage per
// fraction bit, and the output register. A two-entry output buffer keeps query.ready
// a register output; it drops only when two results wait untaken. The query channel is
// sized with LENGTH_BITS and the result channel with RATIO_FRACTION_BITS + 1.
module circle_overlap_union_ratio #(
    parameter int LENGTH_BITS = 16,
    parameter int RATIO_FRACTION_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    cour_query_if.sink           query,
    cour_result_if.source        result
);
    import cour_pkg::*;

    localparam int LW  = LENGTH_BITS;
    localparam int FW  = RATIO_FRACTION_BITS;
    localparam int RW  = FW + 1;
    localparam int LBW = $clog2(LW + 1);
    localparam int PB  = PART_BITS;
    localparam int CB  = CONT_BITS;

    typedef struct packed {
        logic [1:0]    kind;
        logic [PB-1:0] ai;
        logic [PB-1:0] bi;
        logic [PB-1:0] di;
        logic [CB-1:0] ca;
        logic [CB-1:0] cb;
        logic [CB-1:0] cm;
    } s1_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [2*PB-1:0]   a2;
        logic [2*PB-1:0]   b2;
        logic [2*PB-1:0]   d2;
        logic [2*PB+1:0]   sqs;
        logic [2*PB-1:0]   sqd;
        logic [2*CB-1:0]   cm2;
        logic [2*CB-1:0]   ca2;
        logic [2*CB-1:0]   cb2;
    } s2_t;

    typedef struct packed {
        logic [1:0]      kind;
        logic [2*PB-1:0] a2;
        logic [2*PB-1:0] b2;
        logic [2*PB:0]   ab2;
        logic [2*PB+2:0] p1;
        logic [2*PB+2:0] p2;
        logic [63:0]     cnum;
        logic [63:0]     cden;
    } carry_t;

    typedef struct packed {
        carry_t          c;
        logic [2*PB+1:0] mv;
        logic [2*PB-1:0] nv;
    } s3_t;

    typedef struct packed {
        carry_t      c;
        logic [63:0] prod;
    } s4_t;

    typedef struct packed {
        carry_t      c;
        logic [63:0] v;
        logic [63:0] r;
    } sq_t;

    typedef struct packed {
        carry_t      c;
        logic [31:0] k;
        xyz_t        r1;
        xyz_t        r2;
    } cd_t;

    typedef struct packed {
        carry_t      c;
        logic [31:0] k;
        logic [31:0] t1;
        logic [31:0] t2;
    } cl_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] cnum;
        logic [63:0] cden;
        logic [61:0] l1;
        logic [61:0] l2;
        logic [62:0] den;
        logic [60:0] chord;
    } mu_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] cnum;
        logic [63:0] cden;
        logic [62:0] lens;
        logic [62:0] den;
    } ln_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] nsel;
        logic [63:0] dsel;
    } sel_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic        full;
        logic [63:0] nsel;
        logic [63:0] dsel;
    } fl_t;

    typedef struct packed {
        logic [1:0]    kind;
        logic          full;
        logic [64:0]   rem;
        logic [FW-1:0] q;
        logic [63:0]   dd;
    } dv_t;

    typedef struct packed {
        logic [RW-1:0] ratio;
        logic [1:0]    kind;
    } res_t;

    function automatic logic [LBW-1:0] bit_len(input logic [LW-1:0] v);
        logic [LBW-1:0] n;
        n = '0;
        for (int i = 0; i < LW; i++) begin
            if (v[i]) begin
                n = LBW'(i + 1);
            end
        end
        return n;
    endfunction

    // Move the point into the right half plane; y stays non-negative.
    function automatic xyz_t pre_rotate(input logic [31:0] k, input logic [2*PB+2:0] p);
        xyz_t             o;
        logic [XY_W-1:0]  ps;
        ps = {{(XY_W-2*PB-3){p[2*PB+2]}}, p};
        if (p[2*PB+2]) begin
            o.x = XY_W'(k);
            o.y = '0 - ps;
            o.z = ANG_W'(HALF_PI_Q30);
        end
        else begin
            o.x = ps;
            o.y = XY_W'(k);
            o.z = '0;
        end
        return o;
    endfunction

    function automatic xyz_t cordic_step(input xyz_t s, input int i);
        xyz_t                   o;
        logic signed [XY_W-1:0] xs;
        logic signed [XY_W-1:0] ys;
        xs = $signed(s.x) >>> i;
        ys = $signed(s.y) >>> i;
        if ($signed(s.y) > 0) begin
            o.x = s.x + ys;
            o.y = s.y - xs;
            o.z = s.z + ANG_W'(atan_q30(i));
        end
        else begin
            o.x = s.x - ys;
            o.y = s.y + xs;
            o.z = s.z - ANG_W'(atan_q30(i));
        end
        return o;
    endfunction

    function automatic logic [31:0] clamp_angle(input logic [ANG_W-1:0] z);
        logic [31:0] t;
        if (z[ANG_W-1]) begin
            t = '0;
        end
        else if (z > ANG_W'(PI_Q30)) begin
            t = PI_Q30;
        end
        else begin
            t = z[31:0];
        end
        return t;
    endfunction

    // ---------------------------------------------------------------- control
    logic       en;
    logic       push;
    logic       pop;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;

    logic                    v0_reg, v1_reg, v2_reg, v3_reg, v4_reg;
    logic [SQRT_STEPS-1:0]   sq_v_reg;
    logic                    cp_v_reg;
    logic [CORDIC_STEPS-1:0] cr_v_reg;
    logic                    cl_v_reg, mu_v_reg, ln_v_reg, sel_v_reg, fl_v_reg;
    logic [FW-1:0]           dv_v_reg;

    assign en = (fill_reg != 2'd2);
    assign query.ready = en;
    assign push = en && dv_v_reg[FW-1];
    assign result.valid = (fill_reg != 2'd0);
    assign pop = result.valid && result.ready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v0_reg   <= 1'b0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            sq_v_reg <= '0;
            cp_v_reg <= 1'b0;
            cr_v_reg <= '0;
            cl_v_reg <= 1'b0;
            mu_v_reg <= 1'b0;
            ln_v_reg <= 1'b0;
            sel_v_reg <= 1'b0;
            fl_v_reg <= 1'b0;
            dv_v_reg <= '0;
        end
        else if (en) begin
            v0_reg   <= query.valid;
            v1_reg   <= v0_reg;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            sq_v_reg <= {sq_v_reg[SQRT_STEPS-2:0], v4_reg};
            cp_v_reg <= sq_v_reg[SQRT_STEPS-1];
            cr_v_reg <= {cr_v_reg[CORDIC_STEPS-2:0], cp_v_reg};
            cl_v_reg <= cr_v_reg[CORDIC_STEPS-1];
            mu_v_reg <= cl_v_reg;
            ln_v_reg <= mu_v_reg;
            sel_v_reg <= ln_v_reg;
            fl_v_reg <= sel_v_reg;
            dv_v_reg <= {dv_v_reg[FW-2:0], fl_v_reg};
        end
    end

    // ------------------------------------------------------ stage 0: capture
    logic [LW-1:0] a0_reg, b0_reg, d0_reg;

    always_ff @(posedge clk) begin
        if (en) begin
            a0_reg <= query.radius_a;
            b0_reg <= query.radius_b;
            d0_reg <= query.centre_gap;
        end
    end

    // ------------------------------------------- stage 1: classify, normalize
    logic [LW:0]    sum_w;
    logic [LW-1:0]  diff_w, mx_w, mxp_w;
    logic [LBW-1:0] lp_w, lc_w, sp_w, sc_w;
    s1_t            s1_reg, s1_next;

    assign sum_w  = {1'b0, a0_reg} + {1'b0, b0_reg};
    assign diff_w = (a0_reg > b0_reg) ? a0_reg - b0_reg : b0_reg - a0_reg;
    assign mx_w   = (a0_reg > b0_reg) ? a0_reg : b0_reg;
    assign mxp_w  = (d0_reg > mx_w) ? d0_reg : mx_w;
    assign lp_w   = bit_len(mxp_w);
    assign lc_w   = bit_len(mx_w);
    assign sp_w   = (int'(lp_w) > PB) ? LBW'(int'(lp_w) - PB) : '0;
    assign sc_w   = (int'(lc_w) > CB) ? LBW'(int'(lc_w) - CB) : '0;

    always_comb begin
        s1_next.kind = KIND_PARTIAL;
        if ({1'b0, d0_reg} >= sum_w) begin
            s1_next.kind = KIND_APART;
        end
        else if (d0_reg <= diff_w) begin
            s1_next.kind = KIND_CONTAINED;
        end
        s1_next.ai = PB'(a0_reg >> sp_w);
        s1_next.bi = PB'(b0_reg >> sp_w);
        s1_next.di = PB'(d0_reg >> sp_w);
        s1_next.ca = CB'(a0_reg >> sc_w);
        s1_next.cb = CB'(b0_reg >> sc_w);
        s1_next.cm = CB'(mx_w >> sc_w);
    end

    // ------------------------------------------------------ stage 2: squares
    logic [PB:0]   absum_w;
    logic [PB-1:0] abdif_w;
    s2_t           s2_reg, s2_next;

    assign absum_w = {1'b0, s1_reg.ai} + {1'b0, s1_reg.bi};
    assign abdif_w = (s1_reg.ai > s1_reg.bi) ? s1_reg.ai - s1_reg.bi : s1_reg.bi - s1_reg.ai;

    always_comb begin
        s2_next.kind = s1_reg.kind;
        s2_next.a2   = s1_reg.ai * s1_reg.ai;
        s2_next.b2   = s1_reg.bi * s1_reg.bi;
        s2_next.d2   = s1_reg.di * s1_reg.di;
        s2_next.sqs  = absum_w * absum_w;
        s2_next.sqd  = abdif_w * abdif_w;
        s2_next.cm2  = s1_reg.cm * s1_reg.cm;
        s2_next.ca2  = s1_reg.ca * s1_reg.ca;
        s2_next.cb2  = s1_reg.cb * s1_reg.cb;
    end

    // ------------------------------------- stage 3: chord factors and offsets
    logic both_pos_w;
    s3_t  s3_reg, s3_next;

    assign both_pos_w = (s2_reg.sqs > {2'b0, s2_reg.d2}) && (s2_reg.d2 > s2_reg.sqd);

    always_comb begin
        s3_next.c.kind = s2_reg.kind;
        s3_next.c.a2   = s2_reg.a2;
        s3_next.c.b2   = s2_reg.b2;
        s3_next.c.ab2  = {1'b0, s2_reg.a2} + {1'b0, s2_reg.b2};
        s3_next.c.p1   = {3'b0, s2_reg.d2} + {3'b0, s2_reg.a2} - {3'b0, s2_reg.b2};
        s3_next.c.p2   = {3'b0, s2_reg.d2} + {3'b0, s2_reg.b2} - {3'b0, s2_reg.a2};
        s3_next.c.cnum = 64'(s2_reg.cm2);
        s3_next.c.cden = 64'(s2_reg.ca2) + 64'(s2_reg.cb2);
        s3_next.mv     = both_pos_w ? s2_reg.sqs - {2'b0, s2_reg.d2} : '0;
        s3_next.nv     = both_pos_w ? s2_reg.d2 - s2_reg.sqd : '0;
    end

    // ------------------------------------------------ stage 4: radicand product
    s4_t s4_reg, s4_next;

    always_comb begin
        s4_next.c    = s3_reg.c;
        s4_next.prod = s3_reg.mv * s3_reg.nv;
    end

    // -------------------------------------- square root, one result bit a stage
    sq_t sq_reg [SQRT_STEPS];
    sq_t sq_next [SQRT_STEPS];

    always_comb begin
        sq_t         sq_in;
        logic [63:0] bitv;
        logic [63:0] trial;
        for (int j = 0; j < SQRT_STEPS; j++) begin
            if (j == 0) begin
                sq_in.c = s4_reg.c;
                sq_in.v = s4_reg.prod;
                sq_in.r = '0;
            end
            else begin
                sq_in = sq_reg[j-1];
            end
            bitv  = 64'd1 << (62 - 2 * j);
            trial = sq_in.r + bitv;
            sq_next[j] = sq_in;
            if (sq_in.v >= trial) begin
                sq_next[j].v = sq_in.v - trial;
                sq_next[j].r = (sq_in.r >> 1) + bitv;
            end
            else begin
                sq_next[j].r = sq_in.r >> 1;
            end
        end
    end

    // -------------------------------------------------------- pre-rotation
    cd_t cp_reg, cp_next;

    always_comb begin
        cp_next.c  = sq_reg[SQRT_STEPS-1].c;
        cp_next.k  = sq_reg[SQRT_STEPS-1].r[31:0];
        cp_next.r1 = pre_rotate(sq_reg[SQRT_STEPS-1].r[31:0], sq_reg[SQRT_STEPS-1].c.p1);
        cp_next.r2 = pre_rotate(sq_reg[SQRT_STEPS-1].r[31:0], sq_reg[SQRT_STEPS-1].c.p2);
    end

    // ------------------------------------ CORDIC vectoring, both angles per stage
    cd_t cr_reg [CORDIC_STEPS];
    cd_t cr_next [CORDIC_STEPS];

    always_comb begin
        cd_t cr_in;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (i == 0) begin
                cr_in = cp_reg;
            end
            else begin
                cr_in = cr_reg[i-1];
            end
            cr_next[i]    = cr_in;
            cr_next[i].r1 = cordic_step(cr_in.r1, i);
            cr_next[i].r2 = cordic_step(cr_in.r2, i);
        end
    end

    // -------------------------------------------------------- clamp angles
    cl_t cl_reg, cl_next;

    always_comb begin
        cl_next.c  = cr_reg[CORDIC_STEPS-1].c;
        cl_next.k  = cr_reg[CORDIC_STEPS-1].k;
        cl_next.t1 = clamp_angle(cr_reg[CORDIC_STEPS-1].r1.z);
        cl_next.t2 = clamp_angle(cr_reg[CORDIC_STEPS-1].r2.z);
    end

    // -------------------------------------------------------- area products
    mu_t mu_reg, mu_next;

    always_comb begin
        mu_next.kind  = cl_reg.c.kind;
        mu_next.cnum  = cl_reg.c.cnum;
        mu_next.cden  = cl_reg.c.cden;
        mu_next.l1    = cl_reg.c.a2 * cl_reg.t1;
        mu_next.l2    = cl_reg.c.b2 * cl_reg.t2;
        mu_next.den   = PI_Q30 * cl_reg.c.ab2;
        mu_next.chord = {cl_reg.k, 29'b0};
    end

    // ------------------------------------------- lens: sectors minus triangles
    logic [62:0] sect_w;
    ln_t         ln_reg, ln_next;

    assign sect_w = {1'b0, mu_reg.l1} + {1'b0, mu_reg.l2};

    always_comb begin
        ln_next.kind = mu_reg.kind;
        ln_next.cnum = mu_reg.cnum;
        ln_next.cden = mu_reg.cden;
        ln_next.den  = mu_reg.den;
        ln_next.lens = (sect_w > {2'b0, mu_reg.chord}) ? sect_w - {2'b0, mu_reg.chord} : '0;
    end

    // --------------------------------------- union numerator, pick the divide
    sel_t sel_reg, sel_next;

    always_comb begin
        sel_next.kind = ln_reg.kind;
        if (ln_reg.kind == KIND_CONTAINED) begin
            sel_next.nsel = ln_reg.cnum;
            sel_next.dsel = ln_reg.cden;
        end
        else begin
            sel_next.nsel = (ln_reg.lens < ln_reg.den) ? 64'(ln_reg.den - ln_reg.lens) : '0;
            sel_next.dsel = 64'(ln_reg.den);
        end
    end

    // ------------------------------------------- flag results that saturate
    fl_t fl_reg, fl_next;

    always_comb begin
        fl_next.kind = sel_reg.kind;
        fl_next.nsel = sel_reg.nsel;
        fl_next.dsel = sel_reg.dsel;
        fl_next.full = (sel_reg.kind == KIND_APART) || (sel_reg.dsel == '0)
                       || (sel_reg.nsel >= sel_reg.dsel);
    end

    // -------------------------------------- fraction divide, one bit a stage
    dv_t dv_reg [FW];
    dv_t dv_next [FW];

    always_comb begin
        dv_t         dv_in;
        logic [64:0] r2;
        for (int i = 0; i < FW; i++) begin
            if (i == 0) begin
                dv_in.kind = fl_reg.kind;
                dv_in.full = fl_reg.full;
                dv_in.rem  = {1'b0, fl_reg.nsel};
                dv_in.q    = '0;
                dv_in.dd   = fl_reg.dsel;
            end
            else begin
                dv_in = dv_reg[i-1];
            end
            r2 = {dv_in.rem[63:0], 1'b0};
            dv_next[i] = dv_in;
            if (r2 >= {1'b0, dv_in.dd}) begin
                dv_next[i].rem = r2 - {1'b0, dv_in.dd};
                dv_next[i].q   = {dv_in.q[FW-2:0], 1'b1};
            end
            else begin
                dv_next[i].rem = r2;
                dv_next[i].q   = {dv_in.q[FW-2:0], 1'b0};
            end
        end
    end

    // -------------------------------------------------- payload registers
    always_ff @(posedge clk) begin
        if (en) begin
            s1_reg  <= s1_next;
            s2_reg  <= s2_next;
            s3_reg  <= s3_next;
            s4_reg  <= s4_next;
            sq_reg  <= sq_next;
            cp_reg  <= cp_next;
            cr_reg  <= cr_next;
            cl_reg  <= cl_next;
            mu_reg  <= mu_next;
            ln_reg  <= ln_next;
            sel_reg <= sel_next;
            fl_reg  <= fl_next;
            dv_reg  <= dv_next;
        end
    end

    // ---------------------------------------------- two-entry output buffer
    res_t res_new;
    res_t main_reg, skid_reg;

    assign res_new.ratio = dv_reg[FW-1].full ? (RW'(1) << FW) : {1'b0, dv_reg[FW-1].q};
    assign res_new.kind  = dv_reg[FW-1].kind;

    always_comb begin
        case ({push, pop})
            2'b10:   fill_next = fill_reg + 2'd1;
            2'b01:   fill_next = fill_reg - 2'd1;
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            fill_reg <= 2'd0;
        end
        else begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk) begin
        if ((fill_reg == 2'd0 && push) || (fill_reg == 2'd1 && push && pop)) begin
            main_reg <= res_new;
        end
        else if (fill_reg == 2'd2 && pop) begin
            main_reg <= skid_reg;
        end
        // hold the second transaction until the head drains
        if (fill_reg == 2'd1 && push && !pop) begin
            skid_reg <= res_new;
        end
    end

    assign result.union_ratio  = main_reg.ratio;
    assign result.overlap_kind = main_reg.kind;

endmodule

FILE: hw/rtl/cour_checker.sv
// Port-level checks on the circle union ratio block, bound to the top level.
module cour_checker #(
    parameter int RW = 17
) (
    input logic          clk,
    input logic          rst_n,
    input logic          q_ready,
    input logic          r_valid,
    input logic          r_ready,
    input logic [RW-1:0] r_ratio,
    input logic [1:0]    r_kind
);
    import cour_pkg::*;

    localparam logic [RW-1:0] ONE = RW'(1) << (RW - 1);

    a_ratio_max: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid |-> r_ratio <= ONE)
        else $error("union ratio above one");

    a_apart_one: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid && r_kind == KIND_APART |-> r_ratio == ONE)
        else $error("separate circles must give a ratio of one");

    a_ready_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !q_ready |-> r_valid)
        else $error("query stalled with no result waiting");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid && !r_ready |=> r_valid && $stable(r_ratio) && $stable(r_kind))
        else $error("stalled result transaction changed");

endmodule

bind circle_overlap_union_ratio cour_checker #(
    .RW(RATIO_FRACTION_BITS + 1)
) u_cour_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_ready (query.ready),
    .r_valid (result.valid),
    .r_ready (result.ready),
    .r_ratio (result.union_ratio),
    .r_kind  (result.overlap_kind)
);

FILE: tb/cour_ratio_checker.sv
// Checker for the circle union ratio block: predicts each query's result and compares.
module cour_ratio_checker (
    input  logic          clk,
    input  logic          rst_n,
    cour_query_if.sink    query,
    cour_result_if.sink   result,
    output int            fail_count,
    output int            pending,
    output int            checked
);
    import cour_pkg::*;

    typedef struct packed {
        logic [16:0] union_ratio;
        logic [1:0]  overlap_kind;
    } ratio_result_t;

    localparam longint unsigned PI_Q = longint'(PI_Q30);
    localparam longint HALF_PI_Q = longint'(HALF_PI_Q30);

    longint arc_table [30] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
        64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
        64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
        64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
        64'h0000003F, 64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002
    };

    ratio_result_t expected_results [$];

    function automatic int shift_to_fit(longint unsigned v, int target);
        int n;
        n = 0;
        while (v != 0)
        begin
            v = v >> 1;
            n++;
        end
        return (n > target) ? n - target : 0;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= r + bitv)
            begin
                v = v - (r + bitv);
                r = (r >> 1) + bitv;
            end
            else
                r = r >> 1;
            bitv = bitv >> 2;
        end
        return r;
    endfunction

    // Chord half angle in Q30 radians, y >= 0, result clamped to [0, pi].
    function automatic longint unsigned chord_angle(longint y, longint x);
        longint z;
        longint t;
        longint xs;
        longint ys;
        z = 0;
        if (x < 0)
        begin
            t = x;
            x = y;
            y = -t;
            z = HALF_PI_Q;
        end
        for (int i = 0; i < 30; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + arc_table[i];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - arc_table[i];
            end
        end
        if (z < 0)
            z = 0;
        if (longint'(z) > longint'(PI_Q))
            z = longint'(PI_Q);
        return longint'(z);
    endfunction

    function automatic logic [16:0] fraction_of(longint unsigned n, longint unsigned d);
        longint unsigned q;
        longint unsigned rem;
        if (d == 0 || n >= d)
            return 17'h10000;
        q = 0;
        rem = n;
        for (int i = 0; i < 16; i++)
        begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= d)
            begin
                rem = rem - d;
                q = q | 1;
            end
        end
        return q[16:0];
    endfunction

    function automatic ratio_result_t predict_union(logic [15:0] ra, logic [15:0] rb,
                                                    logic [15:0] gap);
        ratio_result_t res;
        longint unsigned a, b, d, diff, mx, k, t1, t2, lens, chord_term, den, num;
        longint ai, bi, di, a2, b2, d2, m, n, p1, p2;
        int s;
        a = ra;
        b = rb;
        d = gap;
        diff = (a > b) ? a - b : b - a;
        mx = (a > b) ? a : b;
        if (d >= a + b)
        begin
            res.overlap_kind = KIND_APART;
            res.union_ratio = 17'h10000;
        end
        else if (d <= diff)
        begin
            s = shift_to_fit(mx, CONT_BITS);
            res.overlap_kind = KIND_CONTAINED;
            res.union_ratio = fraction_of((mx >> s) * (mx >> s),
                                          (a >> s) * (a >> s) + (b >> s) * (b >> s));
        end
        else
        begin
            if (d > mx)
                mx = d;
            s = shift_to_fit(mx, PART_BITS);
            ai = longint'(a >> s);
            bi = longint'(b >> s);
            di = longint'(d >> s);
            a2 = ai * ai;
            b2 = bi * bi;
            d2 = di * di;
            m = (ai + bi) * (ai + bi) - d2;
            n = d2 - (ai - bi) * (ai - bi);
            k = (m > 0 && n > 0) ? int_sqrt(longint'(m) * longint'(n)) : 0;
            p1 = d2 + a2 - b2;
            p2 = d2 + b2 - a2;
            t1 = chord_angle(longint'(k), p1);
            t2 = chord_angle(longint'(k), p2);
            lens = longint'(a2) * t1 + longint'(b2) * t2;
            chord_term = k << 29;
            lens = (lens > chord_term) ? lens - chord_term : 0;
            den = PI_Q * longint'(a2 + b2);
            num = (lens < den) ? den - lens : 0;
            res.overlap_kind = KIND_PARTIAL;
            res.union_ratio = fraction_of(num, den);
        end
        return res;
    endfunction

    assign pending = expected_results.size();

    always @(posedge clk or negedge rst_n)
    begin
        ratio_result_t exp_r;
        if (!rst_n)
        begin
            fail_count <= 0;
            checked <= 0;
            expected_results.delete();
        end
        else
        begin
            if (query.valid && query.ready)
                expected_results.push_back(predict_union(query.radius_a, query.radius_b,
                                                         query.centre_gap));
            if (result.valid && result.ready)
            begin
                checked <= checked + 1;
                if (expected_results.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result ratio=%0d kind=%0d",
                                 result.union_ratio, result.overlap_kind);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (exp_r.union_ratio !== result.union_ratio ||
                        exp_r.overlap_kind !== result.overlap_kind)
                    begin
                        if (fail_count < 10)
                            $display({"mismatch: expected ratio=%0d kind=%0d, ",
                                      "got ratio=%0d kind=%0d"},
                                     exp_r.union_ratio, exp_r.overlap_kind,
                                     result.union_ratio, result.overlap_kind);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

FILE: tb/tb_circle_overlap_union_ratio.sv
// Top of the circle union ratio testbench: clock, reset, query stimulus and verdict.
module tb_circle_overlap_union_ratio;
    localparam int IDLE_LIMIT = 5000;
    localparam int RANDOM_QUERIES = 650;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   checked;
    int   idle_cycles;
    int   sent;

    cour_query_if #(.LENGTH_BITS(16)) query ();
    cour_result_if #(.RATIO_BITS(17)) result ();

    circle_overlap_union_ratio dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .query  (query),
        .result (result)
    );

    cour_ratio_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .query      (query),
        .result     (result),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver stall pattern: switch to a random mode each time mode_cycles wraps.
    int stall_mode;
    int mode_cycles;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result.ready <= 1'b0;
            stall_mode <= 0;
            mode_cycles <= 0;
        end
        else
        begin
            if (mode_cycles == 63)
                stall_mode <= $urandom_range(0, 3);
            mode_cycles <= (mode_cycles + 1) % 64;
            case (stall_mode)
                0:       result.ready <= 1'b1;
                1:       result.ready <= ($urandom_range(0, 1) == 1);
                2:       result.ready <= (mode_cycles[4:0] < 5'd4);
                default: result.ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // Hang detection: no transaction on either channel for too long.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else
        begin
            if ((query.valid && query.ready) || (result.valid && result.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("** circle_overlap_union_ratio: FAILED **");
                $finish;
            end
        end
    end

    int burst_left;

    // Hold the query until accepted; keep valid high inside a burst.
    task automatic send_query(logic [15:0] ra, logic [15:0] rb, logic [15:0] gap);
        int gap_cycles;
        query.valid <= 1'b1;
        query.radius_a <= ra;
        query.radius_b <= rb;
        query.centre_gap <= gap;
        @(posedge clk);
        while (!query.ready)
            @(posedge clk);
        sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 20);
            gap_cycles = $urandom_range(0, 6);
            if (gap_cycles > 0)
            begin
                query.valid <= 1'b0;
                repeat (gap_cycles) @(posedge clk);
            end
        end
    endtask

    function automatic logic [15:0] sized_length();
        int w;
        w = ($urandom_range(0, 9) == 0) ? 16 : $urandom_range(1, 10);
        return 16'($urandom_range(1, (1 << w) - 1));
    endfunction

    task automatic send_random_query();
        logic [15:0] ra;
        logic [15:0] rb;
        int sum;
        int diff;
        int pick;
        ra = sized_length();
        rb = sized_length();
        sum = int'(ra) + int'(rb);
        diff = (ra > rb) ? ra - rb : rb - ra;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            send_query(16'($urandom), 16'($urandom), 16'($urandom));
        else if (pick <= 2 && sum <= 65535)
            send_query(ra, rb, 16'($urandom_range(sum, (sum + 2000 > 65535) ? 65535 : sum + 2000)));
        else if (pick <= 4)
            send_query(ra, rb, 16'($urandom_range(0, diff)));
        else if (sum - 1 > diff + 1)
            send_query(ra, rb, 16'($urandom_range(diff + 1,
                                                  (sum - 1 > 65535) ? 65535 : sum - 1)));
        else
            send_query(ra, rb, 16'(diff));
    endtask

    initial
    begin
        rst_n = 1'b0;
        sent = 0;
        burst_left = 0;
        query.valid = 1'b0;
        query.radius_a = '0;
        query.radius_b = '0;
        query.centre_gap = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, touching, equal circles, concentric, zero radii.
        send_query(16'd1, 16'd1, 16'd0);
        send_query(16'd1, 16'd1, 16'd1);
        send_query(16'd1, 16'd1, 16'd2);
        send_query(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_query(16'hFFFF, 16'hFFFF, 16'd0);
        send_query(16'hFFFF, 16'd1, 16'hFFFE);
        send_query(16'hFFFF, 16'd1, 16'hFFFF);
        send_query(16'd1, 16'hFFFF, 16'hFFFD);
        send_query(16'd100, 16'd50, 16'd150);
        send_query(16'd100, 16'd50, 16'd149);
        send_query(16'd100, 16'd50, 16'd50);
        send_query(16'd100, 16'd50, 16'd51);
        send_query(16'd100, 16'd100, 16'd100);
        send_query(16'd32767, 16'd32768, 16'd40000);
        send_query(16'h8000, 16'h7FFF, 16'h5555);
        send_query(16'h5555, 16'hAAAA, 16'hAAAA);
        send_query(16'd0, 16'd0, 16'd0);
        send_query(16'd0, 16'd5, 16'd3);
        send_query(16'd7, 16'd0, 16'd9);
        send_query(16'd3, 16'd4, 16'd5);
        send_query(16'd40000, 16'd30000, 16'd65535);

        repeat (RANDOM_QUERIES) send_random_query();
        query.valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);

        $display("Sent %0d queries covering apart, touching, partial overlap and containment;",
                 sent);
        $display("checked %0d results under bursty input and varying output stalls.", checked);
        if (fail_count == 0 && pending == 0)
            $display("** circle_overlap_union_ratio: PASSED **");
        else
            $display("** circle_overlap_union_ratio: FAILED **");
        $finish;
    end
endmodule
